@@ hdl/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and fixed-point constants for the hsv to rgb converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// output channel width, the quotient and divider widths follow from it
	localparam int CHANNEL_BITS = 8;

	localparam int HUE_W  = 15;
	localparam int FRAC_W = 13;
	localparam int REM_W  = 12;
	localparam int PROD_W = 25;
	localparam int NUM_W  = 24;
	localparam int ACC_W  = 37;

	localparam int Q_ONE        = 4096;
	localparam int SECTOR_UNITS = 3840;
	localparam int HUE_FULL     = 6 * SECTOR_UNITS;
	localparam int FACT_ONE     = Q_ONE * SECTOR_UNITS;

	// 4096 * 4096 * 3840 = 2^32 * 15
	localparam int SCALE_SHIFT = 32;
	localparam int QUOT_W      = CHANNEL_BITS + 4;

	// reciprocal of 15, exact for every quotient below 2^QUOT_W
	localparam int DIV_SHIFT        = ((CHANNEL_BITS + 8 + 3) / 4) * 4;
	localparam longint DIV_MULT     = ((64'd1 << DIV_SHIFT) + 64'd14) / 64'd15;
	localparam int DIV_PROD_W       = QUOT_W + DIV_SHIFT - 3;

	typedef enum logic [2:0] {
		SECT_RY = 3'd0,
		SECT_YG = 3'd1,
		SECT_GC = 3'd2,
		SECT_CB = 3'd3,
		SECT_BM = 3'd4,
		SECT_MR = 3'd5
	} sector_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [FRAC_W-1:0] saturation;
		logic [FRAC_W-1:0] brightness;
	} hsv_word_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
	} rgb_word_t;

	typedef struct packed {
		sector_t           sector;
		logic [REM_W-1:0]  rem;
		logic [FRAC_W-1:0] sat;
		logic [FRAC_W-1:0] val;
	} sect_word_t;

	typedef struct packed {
		sector_t           sector;
		logic [QUOT_W-1:0] qv;
		logic [QUOT_W-1:0] qp;
		logic [QUOT_W-1:0] qq;
		logic [QUOT_W-1:0] qt;
	} quot_word_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

@@ hdl/hsv2rgb_pre.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pre
// Stage 1: input clamping, hue wrap and sector / remainder decode.
// ----------------------------------------------------------------------------
module hsv2rgb_pre (
	input  logic                    clk,
	input  hsv2rgb_pkg::stage_en_t  en,
	input  hsv2rgb_pkg::hsv_word_t  word,
	output hsv2rgb_pkg::sect_word_t sect_s1
);

	logic [hsv2rgb_pkg::HUE_W-1:0]  hue_c;
	logic [hsv2rgb_pkg::HUE_W-1:0]  base;
	logic [hsv2rgb_pkg::FRAC_W-1:0] sat_c;
	logic [hsv2rgb_pkg::FRAC_W-1:0] val_c;
	hsv2rgb_pkg::sector_t           sector;

	always_comb begin
		hue_c = (word.hue >= hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_FULL)) ?
			'0 : word.hue;
		sat_c = (word.saturation > hsv2rgb_pkg::FRAC_W'(hsv2rgb_pkg::Q_ONE)) ?
			hsv2rgb_pkg::FRAC_W'(hsv2rgb_pkg::Q_ONE) : word.saturation;
		val_c = (word.brightness > hsv2rgb_pkg::FRAC_W'(hsv2rgb_pkg::Q_ONE)) ?
			hsv2rgb_pkg::FRAC_W'(hsv2rgb_pkg::Q_ONE) : word.brightness;
	end

	// hue / 3840 by compare against the five sector boundaries
	always_comb begin
		sector = hsv2rgb_pkg::SECT_RY;
		base   = '0;
		if (hue_c >= hsv2rgb_pkg::HUE_W'(5 * hsv2rgb_pkg::SECTOR_UNITS)) begin
			sector = hsv2rgb_pkg::SECT_MR;
			base   = hsv2rgb_pkg::HUE_W'(5 * hsv2rgb_pkg::SECTOR_UNITS);
		end else if (hue_c >= hsv2rgb_pkg::HUE_W'(4 * hsv2rgb_pkg::SECTOR_UNITS)) begin
			sector = hsv2rgb_pkg::SECT_BM;
			base   = hsv2rgb_pkg::HUE_W'(4 * hsv2rgb_pkg::SECTOR_UNITS);
		end else if (hue_c >= hsv2rgb_pkg::HUE_W'(3 * hsv2rgb_pkg::SECTOR_UNITS)) begin
			sector = hsv2rgb_pkg::SECT_CB;
			base   = hsv2rgb_pkg::HUE_W'(3 * hsv2rgb_pkg::SECTOR_UNITS);
		end else if (hue_c >= hsv2rgb_pkg::HUE_W'(2 * hsv2rgb_pkg::SECTOR_UNITS)) begin
			sector = hsv2rgb_pkg::SECT_GC;
			base   = hsv2rgb_pkg::HUE_W'(2 * hsv2rgb_pkg::SECTOR_UNITS);
		end else if (hue_c >= hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::SECTOR_UNITS)) begin
			sector = hsv2rgb_pkg::SECT_YG;
			base   = hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::SECTOR_UNITS);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sect_s1.sector <= sector;
			sect_s1.rem    <= hsv2rgb_pkg::REM_W'(hue_c - base);
			sect_s1.sat    <= sat_c;
			sect_s1.val    <= val_c;
		end
	end

endmodule

@@ hdl/hsv2rgb_fac.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_fac
// Stages 2-4: factor numerators, value products and scaling by the
// channel maximum, ending in quotients that still need a divide by 15.
// ----------------------------------------------------------------------------
module hsv2rgb_fac (
	input  logic                    clk,
	input  hsv2rgb_pkg::stage_en_t  en,
	input  hsv2rgb_pkg::sect_word_t sect_s1,
	output hsv2rgb_pkg::quot_word_t quot_s4
);

	localparam int CB = hsv2rgb_pkg::CHANNEL_BITS;

	logic [hsv2rgb_pkg::PROD_W-1:0] sp;
	logic [hsv2rgb_pkg::PROD_W-1:0] sq;
	logic [hsv2rgb_pkg::PROD_W-1:0] st;
	logic [hsv2rgb_pkg::REM_W-1:0]  rem_inv;

	hsv2rgb_pkg::sector_t           sector_s2;
	logic [hsv2rgb_pkg::FRAC_W-1:0] val_s2;
	logic [hsv2rgb_pkg::NUM_W-1:0]  np_s2;
	logic [hsv2rgb_pkg::NUM_W-1:0]  nq_s2;
	logic [hsv2rgb_pkg::NUM_W-1:0]  nt_s2;

	hsv2rgb_pkg::sector_t           sector_s3;
	logic [hsv2rgb_pkg::ACC_W-1:0]  av_s3;
	logic [hsv2rgb_pkg::ACC_W-1:0]  ap_s3;
	logic [hsv2rgb_pkg::ACC_W-1:0]  aq_s3;
	logic [hsv2rgb_pkg::ACC_W-1:0]  at_s3;

	// (a << CB) - a is a times the channel maximum, then drop 2^32
	function automatic logic [hsv2rgb_pkg::QUOT_W-1:0] scale(
		input logic [hsv2rgb_pkg::ACC_W-1:0] a
	);
		logic [hsv2rgb_pkg::ACC_W+CB-1:0] w;
		w = {a, {CB{1'b0}}} - {{CB{1'b0}}, a};
		return w[hsv2rgb_pkg::SCALE_SHIFT +: hsv2rgb_pkg::QUOT_W];
	endfunction

	assign rem_inv = hsv2rgb_pkg::REM_W'(hsv2rgb_pkg::SECTOR_UNITS) - sect_s1.rem;
	assign sp = hsv2rgb_pkg::PROD_W'(sect_s1.sat) *
		hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::SECTOR_UNITS);
	assign sq = hsv2rgb_pkg::PROD_W'(sect_s1.sat) * hsv2rgb_pkg::PROD_W'(sect_s1.rem);
	assign st = hsv2rgb_pkg::PROD_W'(sect_s1.sat) * hsv2rgb_pkg::PROD_W'(rem_inv);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sector_s2 <= sect_s1.sector;
			val_s2    <= sect_s1.val;
			np_s2     <= hsv2rgb_pkg::NUM_W'(
				hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::FACT_ONE) - sp);
			nq_s2     <= hsv2rgb_pkg::NUM_W'(
				hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::FACT_ONE) - sq);
			nt_s2     <= hsv2rgb_pkg::NUM_W'(
				hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::FACT_ONE) - st);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sector_s3 <= sector_s2;
			av_s3 <= hsv2rgb_pkg::ACC_W'(val_s2) *
				hsv2rgb_pkg::ACC_W'(hsv2rgb_pkg::FACT_ONE);
			ap_s3 <= hsv2rgb_pkg::ACC_W'(val_s2) * hsv2rgb_pkg::ACC_W'(np_s2);
			aq_s3 <= hsv2rgb_pkg::ACC_W'(val_s2) * hsv2rgb_pkg::ACC_W'(nq_s2);
			at_s3 <= hsv2rgb_pkg::ACC_W'(val_s2) * hsv2rgb_pkg::ACC_W'(nt_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			quot_s4.sector <= sector_s3;
			quot_s4.qv     <= scale(av_s3);
			quot_s4.qp     <= scale(ap_s3);
			quot_s4.qq     <= scale(aq_s3);
			quot_s4.qt     <= scale(at_s3);
		end
	end

endmodule

@@ hdl/hsv2rgb_post.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_post
// Stage 5: divide by 15 through a reciprocal and route by hue sector.
// ----------------------------------------------------------------------------
module hsv2rgb_post (
	input  logic                    clk,
	input  hsv2rgb_pkg::stage_en_t  en,
	input  hsv2rgb_pkg::quot_word_t quot_s4,
	output hsv2rgb_pkg::rgb_word_t  rgb_s5
);

	localparam int CB = hsv2rgb_pkg::CHANNEL_BITS;

	logic [CB-1:0] cv;
	logic [CB-1:0] cp;
	logic [CB-1:0] cq;
	logic [CB-1:0] ct;

	function automatic logic [CB-1:0] div15(input logic [hsv2rgb_pkg::QUOT_W-1:0] q);
		logic [hsv2rgb_pkg::DIV_PROD_W-1:0] prod;
		prod = hsv2rgb_pkg::DIV_PROD_W'(q) *
			hsv2rgb_pkg::DIV_PROD_W'(hsv2rgb_pkg::DIV_MULT);
		return prod[hsv2rgb_pkg::DIV_SHIFT +: CB];
	endfunction

	assign cv = div15(quot_s4.qv);
	assign cp = div15(quot_s4.qp);
	assign cq = div15(quot_s4.qq);
	assign ct = div15(quot_s4.qt);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			case (quot_s4.sector)
				hsv2rgb_pkg::SECT_RY: begin
					rgb_s5 <= {cv, ct, cp};
				end
				hsv2rgb_pkg::SECT_YG: begin
					rgb_s5 <= {cq, cv, cp};
				end
				hsv2rgb_pkg::SECT_GC: begin
					rgb_s5 <= {cp, cv, ct};
				end
				hsv2rgb_pkg::SECT_CB: begin
					rgb_s5 <= {cp, cq, cv};
				end
				hsv2rgb_pkg::SECT_BM: begin
					rgb_s5 <= {ct, cp, cv};
				end
				default: begin
					rgb_s5 <= {cv, cp, cq};
				end
			endcase
		end
	end

endmodule

@@ hdl/hsv_to_rgb_converter_core.sv @@
// Converts one hsv word (hue in 1/64 degree, saturation and brightness as
// Q12 fractions) into an rgb word every clock while the output is not
// stalled, one word per cycle. The path is five register stages deep. Each
// stage moves whenever it is empty or the stage after it moves, so bubbles
// are squeezed out and words keep being taken while a finished result waits
// at the output, until all five stages are full.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Top level: stage valid bits, per-stage enables and the handshakes.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   hsv_valid,
	output logic                   hsv_stall,
	input  hsv2rgb_pkg::hsv_word_t hsv_word,
	output logic                   rgb_valid,
	input  logic                   rgb_stall,
	output hsv2rgb_pkg::rgb_word_t rgb_word
);

	hsv2rgb_pkg::stage_en_t  en;
	hsv2rgb_pkg::sect_word_t sect_s1;
	hsv2rgb_pkg::quot_word_t quot_s4;
	hsv2rgb_pkg::rgb_word_t  rgb_s5;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;

	// a stage loads when it is empty or its contents move on
	always_comb begin
		en.s5 = !valid_s5 || !rgb_stall;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign hsv_stall = !en.s1;
	assign rgb_valid = valid_s5;
	assign rgb_word  = rgb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= hsv_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
		end
	end

	hsv2rgb_pre u_pre (
		.clk     (clk),
		.en      (en),
		.word    (hsv_word),
		.sect_s1 (sect_s1)
	);

	hsv2rgb_fac u_fac (
		.clk     (clk),
		.en      (en),
		.sect_s1 (sect_s1),
		.quot_s4 (quot_s4)
	);

	hsv2rgb_post u_post (
		.clk     (clk),
		.en      (en),
		.quot_s4 (quot_s4),
		.rgb_s5  (rgb_s5)
	);

	// an open output never backs up into the input
	a_no_stall_when_open: assert property (@(posedge clk) disable iff (!arst_n)
		!rgb_stall |-> !hsv_stall)
		else $error("input stalled while output is open");

	// an empty first stage always takes a word
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !hsv_stall)
		else $error("input stalled with first stage empty");

	// a full pipe behind a stalled output must stall the input
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && rgb_stall)
		|-> hsv_stall)
		else $error("input open with pipe full and output stalled");

	// a held word in stage 4 is not lost while stage 5 is stuck
	a_s4_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && valid_s5 && rgb_stall) |=> valid_s4)
		else $error("stage 4 word dropped during stall");

endmodule

@@ test/tb_hsv_to_rgb_converter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_core
// Sends hsv words through the converter with random gaps on the input side
// and random stalls on the output side. Each accepted word is scored against
// an exact integer model of the conversion, in order, channel by channel.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter_core;

	localparam int RANDOM_WORDS = 1950;
	localparam int MAX_IDLE     = 17;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   hsv_valid = 1'b0;
	logic                   hsv_stall;
	hsv2rgb_pkg::hsv_word_t hsv_word  = '0;
	logic                   rgb_valid;
	logic                   rgb_stall = 1'b0;
	hsv2rgb_pkg::rgb_word_t rgb_word;

	hsv2rgb_pkg::hsv_word_t hsv_pending[$];
	hsv2rgb_pkg::rgb_word_t rgb_expected[$];
	int unsigned words_sent    = 0;
	int unsigned words_checked = 0;
	int unsigned send_wait     = 0;
	int unsigned recv_wait     = 0;
	int unsigned error_count   = 0;

	hsv_to_rgb_converter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_stall (hsv_stall),
		.hsv_word  (hsv_word),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall),
		.rgb_word  (rgb_word)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// truncated channel level for v times factor numerator n
	function automatic longint unsigned channel_level(longint unsigned v, longint unsigned n);
		longint unsigned chan_max;
		longint unsigned den;
		chan_max = (longint'(1) << hsv2rgb_pkg::CHANNEL_BITS) - 1;
		den      = longint'(hsv2rgb_pkg::Q_ONE) * longint'(hsv2rgb_pkg::Q_ONE) *
			longint'(hsv2rgb_pkg::SECTOR_UNITS);
		return ((chan_max * v * n) / den) & chan_max;
	endfunction

	function automatic hsv2rgb_pkg::rgb_word_t hsv_to_rgb(hsv2rgb_pkg::hsv_word_t w);
		longint unsigned        hue, sat, val, offs, full;
		longint unsigned        cv, cp, cq, ct;
		hsv2rgb_pkg::rgb_word_t c;
		hue  = w.hue;
		sat  = w.saturation;
		val  = w.brightness;
		full = longint'(hsv2rgb_pkg::Q_ONE) * longint'(hsv2rgb_pkg::SECTOR_UNITS);
		if (sat > hsv2rgb_pkg::Q_ONE) sat = hsv2rgb_pkg::Q_ONE;
		if (val > hsv2rgb_pkg::Q_ONE) val = hsv2rgb_pkg::Q_ONE;
		if (hue >= hsv2rgb_pkg::HUE_FULL) hue = 0;
		offs = hue % hsv2rgb_pkg::SECTOR_UNITS;
		cv = channel_level(val, full);
		cp = channel_level(val, full - sat * hsv2rgb_pkg::SECTOR_UNITS);
		cq = channel_level(val, full - sat * offs);
		ct = channel_level(val, full - sat * (hsv2rgb_pkg::SECTOR_UNITS - offs));
		case (hsv2rgb_pkg::sector_t'(3'(hue / hsv2rgb_pkg::SECTOR_UNITS)))
			hsv2rgb_pkg::SECT_RY: c = {hsv2rgb_pkg::CHANNEL_BITS'(cv),
				hsv2rgb_pkg::CHANNEL_BITS'(ct), hsv2rgb_pkg::CHANNEL_BITS'(cp)};
			hsv2rgb_pkg::SECT_YG: c = {hsv2rgb_pkg::CHANNEL_BITS'(cq),
				hsv2rgb_pkg::CHANNEL_BITS'(cv), hsv2rgb_pkg::CHANNEL_BITS'(cp)};
			hsv2rgb_pkg::SECT_GC: c = {hsv2rgb_pkg::CHANNEL_BITS'(cp),
				hsv2rgb_pkg::CHANNEL_BITS'(cv), hsv2rgb_pkg::CHANNEL_BITS'(ct)};
			hsv2rgb_pkg::SECT_CB: c = {hsv2rgb_pkg::CHANNEL_BITS'(cp),
				hsv2rgb_pkg::CHANNEL_BITS'(cq), hsv2rgb_pkg::CHANNEL_BITS'(cv)};
			hsv2rgb_pkg::SECT_BM: c = {hsv2rgb_pkg::CHANNEL_BITS'(ct),
				hsv2rgb_pkg::CHANNEL_BITS'(cp), hsv2rgb_pkg::CHANNEL_BITS'(cv)};
			default: c = {hsv2rgb_pkg::CHANNEL_BITS'(cv),
				hsv2rgb_pkg::CHANNEL_BITS'(cp), hsv2rgb_pkg::CHANNEL_BITS'(cq)};
		endcase
		return c;
	endfunction

	function automatic hsv2rgb_pkg::hsv_word_t hsv_item(int unsigned h, int unsigned s,
		int unsigned b);
		hsv2rgb_pkg::hsv_word_t w;
		w.hue        = hsv2rgb_pkg::HUE_W'(h);
		w.saturation = hsv2rgb_pkg::FRAC_W'(s);
		w.brightness = hsv2rgb_pkg::FRAC_W'(b);
		return w;
	endfunction

	// mostly in range, sometimes zero or any 13-bit pattern
	function automatic logic [hsv2rgb_pkg::FRAC_W-1:0] random_frac();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return '0;
		if (pick == 1)
			return hsv2rgb_pkg::FRAC_W'($urandom_range(0, (1 << hsv2rgb_pkg::FRAC_W) - 1));
		return hsv2rgb_pkg::FRAC_W'($urandom_range(0, hsv2rgb_pkg::Q_ONE));
	endfunction

	// every fourth stretch of 96 words runs with no idling
	function automatic int unsigned idle_cycles(int unsigned count);
		if ((count / 96) % 4 == 0) return 0;
		return $urandom_range(0, MAX_IDLE);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid <= 1'b0;
			send_wait <= 0;
		end else begin
			if (hsv_valid && !hsv_stall) begin
				rgb_expected.push_back(hsv_to_rgb(hsv_word));
				words_sent = words_sent + 1;
			end
			if (!(hsv_valid && hsv_stall)) begin
				if (send_wait > 0) begin
					send_wait <= send_wait - 1;
					hsv_valid <= 1'b0;
				end else if (hsv_pending.size() > 0) begin
					hsv_word  <= hsv_pending.pop_front();
					hsv_valid <= 1'b1;
					send_wait <= idle_cycles(words_sent);
				end else begin
					hsv_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : rgb_monitor
		int unsigned                         w;
		hsv2rgb_pkg::rgb_word_t              want;
		logic [hsv2rgb_pkg::CHANNEL_BITS-1:0] exp_ch[3];
		logic [hsv2rgb_pkg::CHANNEL_BITS-1:0] got_ch[3];
		string                               ch_name[3];
		if (!arst_n) begin
			rgb_stall <= 1'b0;
			recv_wait <= 0;
		end else begin
			w = recv_wait;
			if (rgb_valid && !rgb_stall) begin
				if (rgb_expected.size() == 0) begin
					$display("%0t: unexpected rgb word expected none got %h", $time, rgb_word);
					error_count = error_count + 1;
				end else begin
					want    = rgb_expected.pop_front();
					exp_ch  = '{want.red, want.green, want.blue};
					got_ch  = '{rgb_word.red, rgb_word.green, rgb_word.blue};
					ch_name = '{"red", "green", "blue"};
					for (int i = 0; i < 3; i++) begin
						if (exp_ch[i] !== got_ch[i]) begin
							$display("%0t: word %0d %s expected %0d got %0d", $time,
								words_checked, ch_name[i], exp_ch[i], got_ch[i]);
							error_count = error_count + 1;
						end
					end
				end
				words_checked = words_checked + 1;
				w = idle_cycles(words_checked);
			end else if (w > 0) begin
				w = w - 1;
			end
			recv_wait <= w;
			rgb_stall <= (w > 0);
		end
	end

	initial begin
		hsv2rgb_pkg::hsv_word_t item;
		int unsigned            k;
		int unsigned            total_words;

		// sector edges at full saturation and value
		hsv_pending.push_back(hsv_item(0, hsv2rgb_pkg::Q_ONE, hsv2rgb_pkg::Q_ONE));
		hsv_pending.push_back(hsv_item(3839, hsv2rgb_pkg::Q_ONE, hsv2rgb_pkg::Q_ONE));
		hsv_pending.push_back(hsv_item(3840, hsv2rgb_pkg::Q_ONE, hsv2rgb_pkg::Q_ONE));
		hsv_pending.push_back(hsv_item(7680, hsv2rgb_pkg::Q_ONE, hsv2rgb_pkg::Q_ONE));
		hsv_pending.push_back(hsv_item(11520, hsv2rgb_pkg::Q_ONE, hsv2rgb_pkg::Q_ONE));
		hsv_pending.push_back(hsv_item(15360, hsv2rgb_pkg::Q_ONE, hsv2rgb_pkg::Q_ONE));
		hsv_pending.push_back(hsv_item(19200, hsv2rgb_pkg::Q_ONE, hsv2rgb_pkg::Q_ONE));
		hsv_pending.push_back(hsv_item(hsv2rgb_pkg::HUE_FULL - 1, hsv2rgb_pkg::Q_ONE,
			hsv2rgb_pkg::Q_ONE));
		// full turn and beyond wrap to zero
		hsv_pending.push_back(hsv_item(hsv2rgb_pkg::HUE_FULL, hsv2rgb_pkg::Q_ONE,
			hsv2rgb_pkg::Q_ONE));
		hsv_pending.push_back(hsv_item(32767, 3000, 2500));
		// grey
		hsv_pending.push_back(hsv_item(5000, 0, hsv2rgb_pkg::Q_ONE));
		hsv_pending.push_back(hsv_item(12000, 0, 2048));
		hsv_pending.push_back(hsv_item(0, 0, 0));
		// fractions above one clamp, then full saturation at zero value
		hsv_pending.push_back(hsv_item(9000, 8191, 8191));
		hsv_pending.push_back(hsv_item(17000, hsv2rgb_pkg::Q_ONE + 1, hsv2rgb_pkg::Q_ONE + 1));
		hsv_pending.push_back(hsv_item(21000, hsv2rgb_pkg::Q_ONE, 0));
		// middle of every sector
		for (k = 0; k < 6; k++)
			hsv_pending.push_back(hsv_item(k * hsv2rgb_pkg::SECTOR_UNITS + 1920, 2048, 3000));

		for (k = 0; k < RANDOM_WORDS; k++) begin
			if ($urandom_range(0, 4) == 0)
				item.hue = hsv2rgb_pkg::HUE_W'($urandom_range(0, (1 << hsv2rgb_pkg::HUE_W) - 1));
			else
				item.hue = hsv2rgb_pkg::HUE_W'($urandom_range(0, hsv2rgb_pkg::HUE_FULL - 1));
			item.saturation = random_frac();
			item.brightness = random_frac();
			hsv_pending.push_back(item);
		end
		total_words = hsv_pending.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (words_checked < total_words) @(posedge clk);
		repeat (20) @(posedge clk);

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
